>>> design/tscst_pkg.sv
package tscst_pkg;

    localparam int TW         = 64;
    localparam int SQW        = 63;
    localparam int NW         = 68;
    localparam int MW         = 68;
    localparam int QW         = 64;
    localparam int DW         = 16;
    localparam int RES_W      = 32;
    localparam int WORK_FRAC  = 40;
    localparam int SQ_FRAC    = 54;
    localparam int TAN_FRAC   = 16;
    localparam int ANGLE_FRAC = 27;

    localparam logic [NW:0] RECIP_ONE = {1'b1, {NW{1'b0}}};

    typedef struct packed {
        logic [SQW-1:0] sq;
        logic           xneg;
        logic [TW-1:0]  term_s;
        logic [TW-1:0]  acc_s;
        logic [TW-1:0]  term_c;
        logic [TW-1:0]  acc_c;
    } t_lane;

    typedef struct packed {
        logic [DW-1:0] ds;
        logic [MW-1:0] ms;
        logic [DW-1:0] dc;
        logic [MW-1:0] mc;
        logic          sine_on;
        logic          minus;
    } t_coef;

    typedef struct packed {
        logic [RES_W-1:0] sine;
        logic [RES_W-1:0] cosine;
        logic [RES_W-1:0] tangent;
        logic             undef;
    } t_result;

endpackage

>>> design/taylor_sine_cosine_tangent.sv
// Throughput: one angle per cycle while o_stall is low; each series term is a 7-stage
// slice with its own multipliers, and the tangent divider retires one quotient bit per
// stage.
// Reset (i_rst_n low, synchronous): drop all in-flight items, clear the output and skid
// valid flags, and set undefined_threshold to 11.
module taylor_sine_cosine_tangent #(
    parameter int SERIES_ORDER     = 50,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_sine,
    output logic signed [31:0] o_cosine,
    output logic signed [31:0] o_tangent,
    output logic               o_tangent_undefined,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int TW  = tscst_pkg::TW;
    localparam int NW  = tscst_pkg::NW;
    localparam int MW  = tscst_pkg::MW;
    localparam int DW  = tscst_pkg::DW;
    localparam int SQW = tscst_pkg::SQW;
    localparam int THR_W = tscst_pkg::RES_W - 1;
    localparam logic             REG_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] THR_RESET     = THR_W'(11);

    logic                 w_en;
    logic [2*32-1:0]      w_sq;
    tscst_pkg::t_lane     n_lane0;
    logic                 w_fin_vld;
    tscst_pkg::t_result   w_fin;

    logic [31:0]          r_a;
    logic                 r_xneg, r_v0, r_v1;
    tscst_pkg::t_lane     r_lane0;
    logic [THR_W-1:0]     r_thr;
    logic                 r_out_vld, r_skid_vld;
    tscst_pkg::t_result   r_out, r_skid;

    tscst_pkg::t_lane     w_lane [0:SERIES_ORDER];
    logic                 w_vld  [0:SERIES_ORDER];

    assign w_en    = !r_skid_vld;
    assign o_stall = r_skid_vld;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_THRESHOLD) ? {1'b0, r_thr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_THRESHOLD)) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign w_sq = r_a * r_a;

    always_comb begin
        n_lane0.sq     = w_sq[SQW-1:0];
        n_lane0.xneg   = r_xneg;
        n_lane0.term_s = TW'(r_a) << (tscst_pkg::WORK_FRAC - tscst_pkg::ANGLE_FRAC);
        n_lane0.acc_s  = TW'(r_a) << (tscst_pkg::WORK_FRAC - tscst_pkg::ANGLE_FRAC);
        n_lane0.term_c = TW'(1) << tscst_pkg::WORK_FRAC;
        n_lane0.acc_c  = TW'(1) << tscst_pkg::WORK_FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a     <= i_angle[31] ? 32'(-i_angle) : i_angle;
            r_xneg  <= i_angle[31];
            r_lane0 <= n_lane0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
        end
    end

    assign w_lane[0] = r_lane0;
    assign w_vld[0]  = r_v1;

    for (genvar k = 1; k <= SERIES_ORDER; k++) begin : g_term
        localparam int DC = (2*k - 1) * (2*k);
        localparam int DS = (2*k) * (2*k + 1);
        localparam logic [NW:0] MC = tscst_pkg::RECIP_ONE / (NW+1)'(DC);
        localparam logic [NW:0] MS = tscst_pkg::RECIP_ONE / (NW+1)'(DS);
        tscst_pkg::t_coef w_coef;

        assign w_coef.ds      = DW'(DS);
        assign w_coef.ms      = MS[MW-1:0];
        assign w_coef.dc      = DW'(DC);
        assign w_coef.mc      = MC[MW-1:0];
        assign w_coef.sine_on = (k < SERIES_ORDER);
        assign w_coef.minus   = ((k % 2) == 1);

        tscst_term u_term (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_valid(w_vld[k-1]), .i_lane(w_lane[k-1]), .i_coef(w_coef),
            .o_valid(w_vld[k]), .o_lane(w_lane[k])
        );
    end

    tscst_final #(.RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_final (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_vld[SERIES_ORDER]), .i_lane(w_lane[SERIES_ORDER]),
        .i_threshold(r_thr),
        .o_valid(w_fin_vld), .o_result(w_fin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_en) begin
            if (w_fin_vld) begin
                if (!r_out_vld || !i_stall) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end else if (!i_stall) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_fin_vld) begin
                if (!r_out_vld || !i_stall) begin
                    r_out <= w_fin;
                end else begin
                    r_skid <= w_fin;
                end
            end
        end else if (!i_stall) begin
            r_out <= r_skid;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_sine              = r_out.sine;
    assign o_cosine            = r_out.cosine;
    assign o_tangent           = r_out.tangent;
    assign o_tangent_undefined = r_out.undef;

endmodule

>>> design/tscst_mul.sv
module tscst_mul #(
    parameter int WA = 64,
    parameter int WB = 64
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [WA-1:0] i_a,
    input  logic [WB-1:0] i_b,
    output logic [WA+WB-1:0] o_p
);

    localparam int LW = 32;
    localparam int AH = WA - LW;
    localparam int BH = WB - LW;
    localparam int PW = WA + WB;

    logic [2*LW-1:0]  r_ll;
    logic [LW+BH-1:0] r_lh;
    logic [AH+LW-1:0] r_hl;
    logic [AH+BH-1:0] r_hh;
    logic [PW-1:0]    r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= (2*LW)'(i_a[LW-1:0]) * (2*LW)'(i_b[LW-1:0]);
            r_lh <= (LW+BH)'(i_a[LW-1:0]) * (LW+BH)'(i_b[WB-1:LW]);
            r_hl <= (AH+LW)'(i_a[WA-1:LW]) * (AH+LW)'(i_b[LW-1:0]);
            r_hh <= (AH+BH)'(i_a[WA-1:LW]) * (AH+BH)'(i_b[WB-1:LW]);
            r_p  <= (PW'(r_hh) << (2*LW)) + (PW'(r_lh) << LW) + (PW'(r_hl) << LW) + PW'(r_ll);
        end
    end

    assign o_p = r_p;

endmodule

>>> design/tscst_term.sv
module tscst_term (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  tscst_pkg::t_lane  i_lane,
    input  tscst_pkg::t_coef  i_coef,
    output logic              o_valid,
    output tscst_pkg::t_lane  o_lane
);

    localparam int TW  = tscst_pkg::TW;
    localparam int SQW = tscst_pkg::SQW;
    localparam int NW  = tscst_pkg::NW;
    localparam int MW  = tscst_pkg::MW;
    localparam int QW  = tscst_pkg::QW;
    localparam int DW  = tscst_pkg::DW;

    logic [TW+SQW-1:0] w_ps, w_pc;
    logic [NW+MW-1:0]  w_ps2, w_pc2;
    logic [NW-1:0]     w_ns, w_nc, w_rs, w_rc;
    logic [QW-1:0]     w_qes, w_qec;
    logic [QW+DW-1:0]  w_qds, w_qdc;

    logic [NW-1:0]    r_ns [0:2];
    logic [NW-1:0]    r_nc [0:2];
    logic [QW-1:0]    r_qes, r_qec, r_qs, r_qc;
    logic [NW-1:0]    r_qds, r_qdc;
    tscst_pkg::t_lane r_lane [0:5];
    tscst_pkg::t_lane r_out, n_out;
    logic [6:0]       r_vld;

    tscst_mul #(.WA(TW), .WB(SQW)) u_mul_s (
        .i_clk(i_clk), .i_en(i_en), .i_a(i_lane.term_s), .i_b(i_lane.sq), .o_p(w_ps)
    );
    tscst_mul #(.WA(TW), .WB(SQW)) u_mul_c (
        .i_clk(i_clk), .i_en(i_en), .i_a(i_lane.term_c), .i_b(i_lane.sq), .o_p(w_pc)
    );

    assign w_ns = w_ps[tscst_pkg::SQ_FRAC +: NW];
    assign w_nc = w_pc[tscst_pkg::SQ_FRAC +: NW];

    tscst_mul #(.WA(NW), .WB(MW)) u_rcp_s (
        .i_clk(i_clk), .i_en(i_en), .i_a(w_ns), .i_b(i_coef.ms), .o_p(w_ps2)
    );
    tscst_mul #(.WA(NW), .WB(MW)) u_rcp_c (
        .i_clk(i_clk), .i_en(i_en), .i_a(w_nc), .i_b(i_coef.mc), .o_p(w_pc2)
    );

    assign w_qes = w_ps2[NW +: QW];
    assign w_qec = w_pc2[NW +: QW];
    assign w_qds = w_qes * i_coef.ds;
    assign w_qdc = w_qec * i_coef.dc;
    assign w_rs  = r_ns[2] - r_qds;
    assign w_rc  = r_nc[2] - r_qdc;

    always_comb begin
        n_out        = r_lane[5];
        n_out.term_c = r_qc;
        n_out.acc_c  = i_coef.minus ? (r_lane[5].acc_c - r_qc) : (r_lane[5].acc_c + r_qc);
        if (i_coef.sine_on) begin
            n_out.term_s = r_qs;
            n_out.acc_s  = i_coef.minus ? (r_lane[5].acc_s - r_qs) : (r_lane[5].acc_s + r_qs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane[0] <= i_lane;
            for (int i = 1; i < 6; i++) begin
                r_lane[i] <= r_lane[i-1];
            end
            r_ns[0] <= w_ns;
            r_nc[0] <= w_nc;
            r_ns[1] <= r_ns[0];
            r_nc[1] <= r_nc[0];
            r_ns[2] <= r_ns[1];
            r_nc[2] <= r_nc[1];
            r_qes   <= w_qes;
            r_qec   <= w_qec;
            r_qds   <= w_qds[NW-1:0];
            r_qdc   <= w_qdc[NW-1:0];
            r_qs    <= (w_rs >= NW'(i_coef.ds)) ? (r_qes + QW'(1)) : r_qes;
            r_qc    <= (w_rc >= NW'(i_coef.dc)) ? (r_qec + QW'(1)) : r_qec;
            r_out   <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    assign o_valid = r_vld[6];
    assign o_lane  = r_out;

endmodule

>>> design/tscst_div.sv
module tscst_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic [DEN_W-1:0] r_rem [0:NUM_W-1];
    logic [NUM_W-1:0] r_nq  [0:NUM_W-1];
    logic [DEN_W-1:0] r_den [0:NUM_W-1];
    logic [TAG_W-1:0] r_tag [0:NUM_W-1];
    logic             r_vld [0:NUM_W-1];

    for (genvar s = 0; s < NUM_W; s++) begin : g_step
        logic [DEN_W-1:0] w_rem_in, w_den_in;
        logic [NUM_W-1:0] w_nq_in;
        logic [TAG_W-1:0] w_tag_in;
        logic             w_vld_in, w_ge;
        logic [DEN_W:0]   w_trial, w_diff;

        if (s == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_nq_in  = i_num;
            assign w_den_in = i_den;
            assign w_tag_in = i_tag;
            assign w_vld_in = i_valid;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_nq_in  = r_nq[s-1];
            assign w_den_in = r_den[s-1];
            assign w_tag_in = r_tag[s-1];
            assign w_vld_in = r_vld[s-1];
        end

        assign w_trial = {w_rem_in, w_nq_in[NUM_W-1]};
        assign w_ge    = w_trial >= {1'b0, w_den_in};
        assign w_diff  = w_trial - {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_nq[s]  <= {w_nq_in[NUM_W-2:0], w_ge};
                r_den[s] <= w_den_in;
                r_tag[s] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_nq[NUM_W-1];
    assign o_tag   = r_tag[NUM_W-1];

endmodule

>>> design/tscst_final.sv
module tscst_final #(
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  tscst_pkg::t_lane               i_lane,
    input  logic [tscst_pkg::RES_W-2:0]    i_threshold,
    output logic                           o_valid,
    output tscst_pkg::t_result             o_result
);

    localparam int TW    = tscst_pkg::TW;
    localparam int RES_W = tscst_pkg::RES_W;
    localparam int SHIFT = tscst_pkg::WORK_FRAC - RESULT_FRAC_BITS;
    localparam int NUM_W = RES_W + tscst_pkg::TAN_FRAC;
    localparam logic [TW-1:0] NEG_LIM = TW'(1) << (RES_W - 1);
    localparam logic [TW-1:0] POS_LIM = NEG_LIM - TW'(1);

    typedef struct packed {
        logic [RES_W-1:0] sine;
        logic [RES_W-1:0] cosine;
        logic             undef;
        logic             tneg;
    } t_divtag;

    logic [TW-1:0]    w_sabs, w_cabs, w_slim, w_clim;
    logic             w_sneg, w_cneg, w_undef, w_qneg;
    logic [RES_W-1:0] w_smag, w_cmag, w_sres, w_cres, w_tmag, w_tan;
    logic [NUM_W-1:0] w_quo, w_qlim;
    logic             w_dvld;
    t_divtag          w_tag, w_dtag;

    logic [TW-1:0]      r1_sm, r1_cm;
    logic               r1_sn, r1_cn, r_vld1, r_vld2, r_vld3;
    logic [NUM_W-1:0]   r2_num;
    logic [RES_W-1:0]   r2_den;
    t_divtag            r2_tag;
    tscst_pkg::t_result r3_res;

    assign w_sabs = i_lane.acc_s[TW-1] ? (TW'(0) - i_lane.acc_s) : i_lane.acc_s;
    assign w_cabs = i_lane.acc_c[TW-1] ? (TW'(0) - i_lane.acc_c) : i_lane.acc_c;

    always_comb begin
        w_sneg  = r1_sn && (r1_sm != '0);
        w_cneg  = r1_cn && (r1_cm != '0);
        w_slim  = w_sneg ? NEG_LIM : POS_LIM;
        w_clim  = w_cneg ? NEG_LIM : POS_LIM;
        w_smag  = (r1_sm > w_slim) ? w_slim[RES_W-1:0] : r1_sm[RES_W-1:0];
        w_cmag  = (r1_cm > w_clim) ? w_clim[RES_W-1:0] : r1_cm[RES_W-1:0];
        w_sres  = w_sneg ? (RES_W'(0) - w_smag) : w_smag;
        w_cres  = w_cneg ? (RES_W'(0) - w_cmag) : w_cmag;
        w_undef = (w_cmag == '0) || (w_cmag < {1'b0, i_threshold});
        w_tag.sine   = w_sres;
        w_tag.cosine = w_cres;
        w_tag.undef  = w_undef;
        w_tag.tneg   = w_sneg != w_cneg;
    end

    tscst_div #(.NUM_W(NUM_W), .DEN_W(RES_W), .TAG_W($bits(t_divtag))) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en),
        .i_valid(r_vld2), .i_num(r2_num), .i_den(r2_den), .i_tag(r2_tag),
        .o_valid(w_dvld), .o_quo(w_quo), .o_tag(w_dtag)
    );

    always_comb begin
        w_qneg = w_dtag.tneg && (w_quo != '0);
        w_qlim = w_qneg ? NEG_LIM[NUM_W-1:0] : POS_LIM[NUM_W-1:0];
        w_tmag = (w_quo > w_qlim) ? w_qlim[RES_W-1:0] : w_quo[RES_W-1:0];
        w_tan  = w_dtag.undef ? '0 : (w_qneg ? (RES_W'(0) - w_tmag) : w_tmag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sm  <= w_sabs >> SHIFT;
            r1_cm  <= w_cabs >> SHIFT;
            r1_sn  <= i_lane.acc_s[TW-1] ^ i_lane.xneg;
            r1_cn  <= i_lane.acc_c[TW-1];
            r2_num <= {w_smag, {tscst_pkg::TAN_FRAC{1'b0}}};
            r2_den <= w_cmag;
            r2_tag <= w_tag;
            r3_res.sine    <= w_dtag.sine;
            r3_res.cosine  <= w_dtag.cosine;
            r3_res.tangent <= w_tan;
            r3_res.undef   <= w_dtag.undef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= w_dvld;
        end
    end

    assign o_valid  = r_vld3;
    assign o_result = r3_res;

endmodule

>>> design/tscst_checker.sv
module tscst_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic signed [31:0] i_angle,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_sine,
    input logic signed [31:0] o_cosine,
    input logic signed [31:0] o_tangent,
    input logic               o_tangent_undefined,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [2:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sine) && $stable(o_cosine)
                               && $stable(o_tangent) && $stable(o_tangent_undefined))
        else $error("stalled result changed");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tangent_undefined |-> o_tangent == 32'sd0)
        else $error("undefined tangent is not zero");

    a_zero_cos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cosine == 32'sd0 |-> o_tangent_undefined)
        else $error("zero cosine without undefined flag");

endmodule

bind taylor_sine_cosine_tangent tscst_checker u_tscst_checker (.*);
